// ===== sv/sadt_pkg.sv =====
package sadt_pkg;

	localparam int TableDepth = 1024;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int KeyW = 40;
	localparam int HandleW = 16;
	localparam int AgeW = 8;
	localparam int EntryW = KeyW + HandleW + AgeW;
	localparam logic [AgeW-1:0] AgeLimitReset = 8'd60;
	localparam logic [AgeW-1:0] AgeMax = 8'hFF;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_LOOKUP   = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_SPARE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_UPDATED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_TICK      = 3'd5
	} status_t;

	typedef struct packed {
		logic [KeyW-1:0]    key;
		logic [HandleW-1:0] handle;
		logic [AgeW-1:0]    age;
	} entry_t;

	// memory access request from the sequencer
	typedef struct packed {
		logic            we;
		logic [IdxW-1:0] waddr;
		entry_t          wdata;
		logic [IdxW-1:0] raddr;
	} mem_req_t;

endpackage

// ===== sv/sorted_aging_device_table.sv =====
// Sorted device table, 1024 entries in one synchronous RAM. Commands are taken
// on start while busy is low; the single result appears for one cycle with
// done high and cannot be stalled. Lookup and register-hit do one RAM read
// per binary-search step. Insert adds an upward shift of the entries above
// the insert position, and a tick does one RAM read per entry, compacting in
// place through the single write port.
module sorted_aging_device_table import sadt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [KeyW-1:0]    device_key,
	input  logic [HandleW-1:0] link_handle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [AgeW-1:0]    cfg_data,
	output logic               done,
	output logic [2:0]         status,
	output logic [9:0]         entry_index,
	output logic [15:0]        found_handle,
	output logic [10:0]        entries_in_use,
	output logic [10:0]        removed_count
);

	logic [AgeW-1:0] age_limit_q;
	mem_req_t        req;
	entry_t          rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AgeLimitReset;
		end else if (cfg_valid) begin
			age_limit_q <= cfg_data;
		end
	end

	sadt_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr),
		.rdata (rdata)
	);

	sadt_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.device_key     (device_key),
		.link_handle    (link_handle),
		.age_limit      (age_limit_q),
		.req            (req),
		.rdata          (rdata),
		.done           (done),
		.status         (status),
		.entry_index    (entry_index),
		.found_handle   (found_handle),
		.entries_in_use (entries_in_use),
		.removed_count  (removed_count)
	);

endmodule

// ===== sv/sadt_ram.sv =====
module sadt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/sadt_seq.sv =====
module sadt_seq import sadt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [KeyW-1:0]    device_key,
	input  logic [HandleW-1:0] link_handle,
	input  logic [AgeW-1:0]    age_limit,
	output mem_req_t           req,
	input  entry_t             rdata,
	output logic               done,
	output logic [2:0]         status,
	output logic [9:0]         entry_index,
	output logic [15:0]        found_handle,
	output logic [10:0]        entries_in_use,
	output logic [10:0]        removed_count
);

	typedef enum logic [2:0] {
		S_IDLE, S_SRCH, S_SWAIT, S_CHECK, S_SHIFT, S_TICK
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [KeyW-1:0]    key_q;
	logic [HandleW-1:0] handle_q;
	logic [CntW-1:0]    count_q;
	logic [CntW-1:0]    lo_q, hi_q, mid_q;
	logic [CntW-1:0]    rd_q;   // next read address for shift/tick
	logic [CntW-1:0]    wr_q;   // next write address
	logic [CntW-1:0]    rem_q;
	logic               pend_q; // read data in flight
	logic [CntW-1:0]    mid_c;

	assign busy = (state_q != S_IDLE);
	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		req = '0;
		case (state_q)
			S_SRCH: begin
				req.raddr = mid_c[IdxW-1:0];
			end
			S_SWAIT: begin
				req.raddr = lo_q[IdxW-1:0];
			end
			S_CHECK: begin
				req.raddr = lo_q[IdxW-1:0];
				if (cmd_q == CMD_REGISTER && rdata.key == key_q && lo_q < count_q) begin
					req.we = 1'b1;
					req.waddr = lo_q[IdxW-1:0];
					req.wdata = '{key: key_q, handle: handle_q, age: '0};
				end
			end
			S_SHIFT: begin
				// walk down from the top: read i-1, write it to i
				req.raddr = rd_q[IdxW-1:0];
				if (pend_q) begin
					req.we = 1'b1;
					req.waddr = wr_q[IdxW-1:0];
					req.wdata = rdata;
				end else if (wr_q == lo_q) begin
					req.we = 1'b1;
					req.waddr = wr_q[IdxW-1:0];
					req.wdata = '{key: key_q, handle: handle_q, age: '0};
				end
			end
			S_TICK: begin
				req.raddr = rd_q[IdxW-1:0];
				if (pend_q && rdata.age <= age_limit) begin
					req.we = 1'b1;
					req.waddr = wr_q[IdxW-1:0];
					req.wdata = '{key: rdata.key, handle: rdata.handle,
						age: (rdata.age == AgeMax) ? AgeMax : rdata.age + 1'b1};
				end
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done <= 1'b0;
			pend_q <= 1'b0;
			status <= '0;
			entry_index <= '0;
			found_handle <= '0;
			entries_in_use <= '0;
			removed_count <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd_t'(command);
						key_q <= device_key;
						handle_q <= link_handle;
						lo_q <= '0;
						hi_q <= count_q;
						rd_q <= '0;
						wr_q <= '0;
						rem_q <= '0;
						pend_q <= 1'b0;
						state_q <= (command == CMD_TICK) ? S_TICK : S_SRCH;
					end
				end
				S_SRCH: begin
					if (pend_q) begin
						pend_q <= 1'b0;
						if (rdata.key < key_q) begin
							lo_q <= mid_q + 1'b1;
						end else begin
							hi_q <= mid_q;
						end
					end else if (lo_q < hi_q) begin
						mid_q <= mid_c;
						pend_q <= 1'b1;
					end else begin
						state_q <= S_SWAIT;
					end
				end
				S_SWAIT: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					removed_count <= '0;
					entries_in_use <= 11'(count_q);
					if (lo_q < count_q && rdata.key == key_q) begin
						done <= 1'b1;
						entry_index <= 10'(lo_q);
						if (cmd_q == CMD_REGISTER) begin
							status <= ST_UPDATED;
							found_handle <= '0;
						end else begin
							status <= ST_FOUND;
							found_handle <= rdata.handle;
						end
						state_q <= S_IDLE;
					end else if (cmd_q != CMD_REGISTER) begin
						done <= 1'b1;
						status <= ST_NOT_FOUND;
						entry_index <= '0;
						found_handle <= '0;
						state_q <= S_IDLE;
					end else if (count_q >= CntW'(TableDepth)) begin
						done <= 1'b1;
						status <= ST_FULL;
						entry_index <= '0;
						found_handle <= '0;
						state_q <= S_IDLE;
					end else begin
						wr_q <= count_q;
						rd_q <= count_q - 1'b1;
						pend_q <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (pend_q) begin
						pend_q <= 1'b0;
						wr_q <= wr_q - 1'b1;
					end else if (wr_q == lo_q) begin
						count_q <= count_q + 1'b1;
						done <= 1'b1;
						status <= ST_INSERTED;
						entry_index <= 10'(lo_q);
						found_handle <= '0;
						removed_count <= '0;
						entries_in_use <= 11'(count_q + 1'b1);
						state_q <= S_IDLE;
					end else begin
						pend_q <= 1'b1;
						rd_q <= rd_q - 1'b1;
					end
				end
				S_TICK: begin
					// one read issued per cycle, result handled in the following cycle
					if (pend_q) begin
						if (rdata.age <= age_limit) begin
							wr_q <= wr_q + 1'b1;
						end else begin
							rem_q <= rem_q + 1'b1;
						end
					end
					if (rd_q < count_q) begin
						pend_q <= 1'b1;
						rd_q <= rd_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							count_q <= wr_q;
							done <= 1'b1;
							status <= ST_TICK;
							entry_index <= '0;
							found_handle <= '0;
							entries_in_use <= 11'(wr_q);
							removed_count <= 11'(rem_q);
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/sadt_checker.sv =====
module sadt_assertions import sadt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [15:0] found_handle,
	input logic [10:0] entries_in_use,
	input logic [10:0] removed_count
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	a_removed_tick: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_TICK |-> removed_count == '0)
		else $error("removed count outside tick");

	a_handle_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_FOUND |-> found_handle == '0)
		else $error("handle outside lookup hit");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> entries_in_use <= 11'(TableDepth)) else $error("count overflow");

endmodule

bind sorted_aging_device_table sadt_assertions u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .found_handle(found_handle),
	.entries_in_use(entries_in_use), .removed_count(removed_count)
);

// ===== tb/sv/sadt_checker.sv =====
`default_nettype none

module sadt_checker import sadt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [1:0]         command,
	input  wire logic [KeyW-1:0]    device_key,
	input  wire logic [HandleW-1:0] link_handle,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [AgeW-1:0]    cfg_data,
	input  wire logic               done,
	input  wire logic [2:0]         status,
	input  wire logic [9:0]         entry_index,
	input  wire logic [15:0]        found_handle,
	input  wire logic [10:0]        entries_in_use,
	input  wire logic [10:0]        removed_count,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t      st;
		logic [9:0]   idx;
		logic [15:0]  hdl;
		logic [10:0]  in_use;
		logic [10:0]  removed;
	} outcome_t;

	logic [KeyW-1:0]    keys [TableDepth];
	logic [HandleW-1:0] handles [TableDepth];
	logic [AgeW-1:0]    ages [TableDepth];
	int                 used = 0;
	logic [AgeW-1:0]    limit = AgeLimitReset;
	outcome_t           awaited [$];

	initial errors = 0;
	assign pending = awaited.size();

	// first position whose key is not below k
	function automatic int search_pos(logic [KeyW-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = used;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (keys[mid] < k) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	task automatic apply_command(input cmd_t cmd, input logic [KeyW-1:0] k,
			input logic [HandleW-1:0] h, output outcome_t o);
		int pos;
		int w;
		int gone;
		bit hit;
		o = '0;
		if (cmd == CMD_TICK) begin
			w = 0;
			gone = 0;
			for (int i = 0; i < used; i++) begin
				if (ages[i] > limit) begin
					gone++;
				end else begin
					keys[w] = keys[i];
					handles[w] = handles[i];
					ages[w] = (ages[i] == AgeMax) ? AgeMax : ages[i] + 1'b1;
					w++;
				end
			end
			used = w;
			o.st = ST_TICK;
			o.removed = gone[10:0];
		end else begin
			pos = search_pos(k);
			hit = (pos < used) && (keys[pos] == k);
			if (cmd == CMD_REGISTER) begin
				if (hit) begin
					handles[pos] = h;
					ages[pos] = '0;
					o.st = ST_UPDATED;
					o.idx = pos[9:0];
				end else if (used >= TableDepth) begin
					o.st = ST_FULL;
				end else begin
					for (int i = used; i > pos; i--) begin
						keys[i] = keys[i-1];
						handles[i] = handles[i-1];
						ages[i] = ages[i-1];
					end
					keys[pos] = k;
					handles[pos] = h;
					ages[pos] = '0;
					used++;
					o.st = ST_INSERTED;
					o.idx = pos[9:0];
				end
			end else if (hit) begin
				o.st = ST_FOUND;
				o.idx = pos[9:0];
				o.hdl = handles[pos];
			end else begin
				o.st = ST_NOT_FOUND;
			end
		end
		o.in_use = used[10:0];
	endtask

	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			used = 0;
			limit = AgeLimitReset;
			awaited.delete();
		end else begin
			if (done) begin
				got = {status_t'(status), entry_index, found_handle, entries_in_use,
					removed_count};
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: result with none awaited: status %0d idx %0d", $time,
						status, entry_index);
				end else begin
					want = awaited.pop_front();
					if (got.st != want.st) begin
						errors++;
						$display("%0t: status expected %0d got %0d", $time, want.st, got.st);
					end
					if (got.idx != want.idx) begin
						errors++;
						$display("%0t: entry_index expected %0d got %0d", $time, want.idx,
							got.idx);
					end
					if (got.hdl != want.hdl) begin
						errors++;
						$display("%0t: found_handle expected %h got %h", $time, want.hdl,
							got.hdl);
					end
					if (got.in_use != want.in_use) begin
						errors++;
						$display("%0t: entries_in_use expected %0d got %0d", $time,
							want.in_use, got.in_use);
					end
					if (got.removed != want.removed) begin
						errors++;
						$display("%0t: removed_count expected %0d got %0d", $time,
							want.removed, got.removed);
					end
				end
			end
			if (cfg_valid && cfg_ready) limit = cfg_data;
			if (start && !busy) begin
				apply_command(cmd_t'(command), device_key, link_handle, want);
				awaited.push_back(want);
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
	import sadt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         command = CMD_LOOKUP;
	logic [KeyW-1:0]    device_key = '0;
	logic [HandleW-1:0] link_handle = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [AgeW-1:0]    cfg_data = '0;
	logic               done;
	logic [2:0]         status;
	logic [9:0]         entry_index;
	logic [15:0]        found_handle;
	logic [10:0]        entries_in_use;
	logic [10:0]        removed_count;
	int                 errors;
	int                 pending;
	int                 gap_pct = 0;
	logic [KeyW-1:0]    key_pool [48];

	always #5 clk = ~clk;

	sorted_aging_device_table dut (.*);

	sadt_checker u_checker (.*);

	function automatic logic [KeyW-1:0] any_key();
		return KeyW'({$urandom, $urandom});
	endfunction

	// called at a falling edge; returns at the falling edge after the beat
	task automatic issue(input cmd_t cmd, input logic [KeyW-1:0] k,
			input logic [HandleW-1:0] h);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		device_key <= k;
		link_handle <= h;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// write age_limit while idle
	task automatic set_limit(input logic [AgeW-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 62) issue(CMD_REGISTER, key_pool[$urandom_range(47)], 16'($urandom));
			else if (r < 78) issue(CMD_LOOKUP, key_pool[$urandom_range(47)], 16'($urandom));
			else if (r < 86) issue(CMD_LOOKUP, any_key(), 16'($urandom));
			else if (r < 96) issue(CMD_TICK, any_key(), 16'($urandom));
			else issue(CMD_SPARE, key_pool[$urandom_range(47)], 16'($urandom));
		end
	endtask

	initial begin
		logic [KeyW-1:0] k;
		key_pool[0] = '0;
		key_pool[1] = {KeyW{1'b1}};
		for (int i = 2; i < 48; i++) key_pool[i] = any_key();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, extremes, hit and miss, spare command
		issue(CMD_LOOKUP, '0, '0);
		issue(CMD_TICK, '0, '0);
		issue(CMD_REGISTER, {KeyW{1'b1}}, 16'hFFFF);
		issue(CMD_REGISTER, '0, '0);
		issue(CMD_REGISTER, 40'h80_0000_0000, 16'h5A5A);
		issue(CMD_REGISTER, 40'h80_0000_0000, 16'hA5A5);
		issue(CMD_LOOKUP, 40'h80_0000_0000, '0);
		issue(CMD_LOOKUP, {KeyW{1'b1}}, '0);
		issue(CMD_LOOKUP, 40'h7F_FFFF_FFFF, '0);
		issue(CMD_SPARE, '0, 16'hFFFF);
		issue(CMD_SPARE, 40'h12_3456_789A, '0);
		issue(CMD_TICK, '0, '0);
		issue(CMD_REGISTER, '0, 16'h1234);
		set_limit(8'd0);
		issue(CMD_TICK, '0, '0);
		issue(CMD_TICK, '0, '0);
		issue(CMD_LOOKUP, '0, '0);

		// fill part of the table in ascending order, insert a random key, then clear
		set_limit(8'd255);
		for (int i = 0; i < 80; i++) begin
			k = {i[9:0], 30'($urandom)};
			issue(CMD_REGISTER, k, 16'($urandom));
		end
		issue(CMD_REGISTER, any_key(), 16'h0F0F);
		issue(CMD_REGISTER, k, 16'hF0F0);
		issue(CMD_LOOKUP, k, '0);
		issue(CMD_TICK, '0, '0);
		issue(CMD_REGISTER, k, 16'h3C3C);
		set_limit(8'd0);
		issue(CMD_TICK, '0, '0);
		issue(CMD_TICK, '0, '0);

		gap_pct = 0;
		set_limit(8'd1);
		random_phase(50);
		gap_pct = 54;
		set_limit(8'd3);
		random_phase(50);
		gap_pct = 0;
		set_limit(8'($urandom_range(2, 254)));
		random_phase(50);
		gap_pct = 27;
		set_limit(8'd0);
		random_phase(50);

		// age saturation: nothing leaves with the top limit
		gap_pct = 0;
		set_limit(8'd255);
		for (int i = 0; i < 6; i++) issue(CMD_REGISTER, key_pool[i], 16'($urandom));
		for (int i = 0; i < 260; i++) issue(CMD_TICK, any_key(), '0);
		for (int i = 0; i < 6; i++) issue(CMD_LOOKUP, key_pool[i], '0);
		set_limit(8'd254);
		issue(CMD_TICK, '0, '0);

		drain();
		repeat (40) @(negedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
